@@ sv/alfr_pkg.sv @@
package alfr_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned GAP_W  = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned FILL_W = 7;
  localparam int unsigned SUM_W  = 20;

  // frame queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [GAP_W-1:0]  GAP_RESET = 16'd10;
  localparam logic [LEN_W-1:0]  LEN_MAX   = 16'hFFFF;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
  localparam logic [FILL_W-1:0] TAG_LEN   = 7'd6;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // one completed frame handed from front to back
  typedef struct packed {
    logic              bank;
    logic [FILL_W-1:0] len;
    logic              kind;
    logic              trunc;
  } alfr_frame_t;

  // characters of the "+recv=" header
  function automatic logic [BYTE_W-1:0] tag_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h63;
      3'd4:    ch = 8'h76;
      3'd5:    ch = 8'h3D;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/alfr_in_if.sv @@
interface alfr_in_if;
  import alfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic [TIME_W-1:0] arrival_ms;

  modport source(output valid, output rx_byte, output arrival_ms, input ready);
  modport sink(input valid, input rx_byte, input arrival_ms, output ready);
endinterface

@@ sv/alfr_out_if.sv @@
interface alfr_out_if;
  import alfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              is_last;
  logic              frame_kind;
  logic              truncated;

  modport source(output valid, output frame_byte, output is_last, output frame_kind,
                 output truncated, input ready);
  modport sink(input valid, input frame_byte, input is_last, input frame_kind,
               input truncated, output ready);
endinterface

@@ sv/at_line_and_length_frame_receiver.sv @@
// Line and length framer for the byte stream of an AT-command radio module. Each input
// item is one received byte with its millisecond timestamp; a silence longer than
// gap_timeout_ms before a byte drops any partial frame. Newline-terminated lines are
// sent out as command lines (kind 0); a line starting "+recv=N" is closed with a zero
// byte and followed by N counted payload bytes, the whole sent out as a data frame
// (kind 1). Frames leave one byte per item with a last mark and a truncated flag when
// the STORE_BYTES-byte store overflowed. An input byte is taken in the cycle it is
// offered while there is room. A finished frame drains at one byte per clock, while the
// output is ready, from a two-bank store through its registered read port. The input stalls
// only while two finished frames are still waiting (one draining, one queued), since
// both store banks are then held.
module at_line_and_length_frame_receiver #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [alfr_pkg::GAP_W-1:0] cfg_wdata_i,
  alfr_in_if.sink                    rx_i,
  alfr_out_if.source                 frame_o
);
  import alfr_pkg::*;

  // per-bank address width; the store holds two banks
  localparam int unsigned AW    = $clog2(STORE_BYTES);
  localparam int unsigned DEPTH = 2 << AW;

  // gap timeout register
  logic [GAP_W-1:0] gap_q;

  // store ports
  logic              st_we;
  logic [AW:0]       st_waddr;
  logic [BYTE_W-1:0] st_wdata;
  logic              st_re;
  logic [AW:0]       st_raddr;
  logic [BYTE_W-1:0] st_rdata;

  // frame queue
  logic              q_push;
  alfr_frame_t       q_push_data;
  logic              q_pop;
  logic              q_valid;
  alfr_frame_t       q_pop_data;
  logic [QCNT_W-1:0] q_count;

  logic back_busy;
  logic room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GAP_RESET;
    end else if (cfg_we_i) begin
      gap_q <= cfg_wdata_i;
    end
  end

  // the bank the front writes is free unless two frames are held
  assign room = (q_count == '0) || ((q_count == QCNT_W'(1)) && !back_busy);

  // classify bytes, track framing state, fill the store
  alfr_front #(
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .room_i      (room),
    .gap_i       (gap_q),
    .we_o        (st_we),
    .waddr_o     (st_waddr),
    .wdata_o     (st_wdata),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  // two-bank frame store
  alfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // completed frame descriptors
  alfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_pop_data),
    .count_o     (q_count)
  );

  // stream frames out of the store
  alfr_back #(
    .AW (AW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_pop_data),
    .q_pop_o   (q_pop),
    .busy_o    (back_busy),
    .re_o      (st_re),
    .raddr_o   (st_raddr),
    .rdata_i   (st_rdata),
    .frame_o   (frame_o)
  );

endmodule

@@ sv/alfr_ram.sv @@
module alfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/alfr_queue.sv @@
module alfr_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  alfr_pkg::alfr_frame_t     push_data_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output alfr_pkg::alfr_frame_t     pop_data_o,
  output logic [alfr_pkg::QCNT_W-1:0] count_o
);
  import alfr_pkg::*;

  alfr_frame_t        slot_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign count_o    = cnt_q;

endmodule

@@ sv/alfr_front.sv @@
module alfr_front #(
  parameter int unsigned STORE_BYTES = 64,
  parameter int unsigned AW          = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  alfr_in_if.sink                    rx_i,
  input  logic                       room_i,
  input  logic [alfr_pkg::GAP_W-1:0] gap_i,
  output logic                       we_o,
  output logic [AW:0]                waddr_o,
  output logic [alfr_pkg::BYTE_W-1:0] wdata_o,
  output logic                       push_o,
  output alfr_pkg::alfr_frame_t      push_data_o
);
  import alfr_pkg::*;

  localparam logic [FILL_W-1:0] BUF_LEN = FILL_W'(STORE_BYTES);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  acc_q, acc_d;
  logic              dend_q, dend_d;
  logic              tag_q, tag_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic              bank_q, bank_d;

  logic              accept;
  logic [BYTE_W-1:0] ch;
  logic [TIME_W-1:0] gap_diff;
  logic              gap_hit;
  logic [FILL_W-1:0] fill_e;
  logic              ovf_e, dend_e, tag_e;
  logic [LEN_W-1:0]  rem_e, acc_e;
  logic              wr_room;
  logic              store_en;
  logic [BYTE_W-1:0] store_data;
  logic              emit;
  logic              emit_kind;
  logic [FILL_W-1:0] fill_s;
  logic              ovf_s;
  logic [SUM_W-1:0]  acc_sum;
  logic              is_digit;

  assign accept   = rx_i.valid && room_i;
  assign rx_i.ready = room_i;
  assign ch       = rx_i.rx_byte;
  assign gap_diff = rx_i.arrival_ms - last_q - {{(TIME_W-GAP_W){1'b0}}, gap_i};
  assign gap_hit  = (gap_diff != '0) && !gap_diff[TIME_W-1];

  // frame state as seen after a possible silence drop
  assign fill_e = gap_hit ? '0   : fill_q;
  assign ovf_e  = gap_hit ? 1'b0 : ovf_q;
  assign rem_e  = gap_hit ? '0   : rem_q;
  assign acc_e  = gap_hit ? '0   : acc_q;
  assign dend_e = gap_hit ? 1'b0 : dend_q;
  assign tag_e  = gap_hit ? 1'b1 : tag_q;

  assign wr_room  = !ovf_e && (fill_e < BUF_LEN);
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign acc_sum  = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0}
                  + {{(SUM_W-4){1'b0}}, ch[3:0]};

  always_comb begin
    store_en   = 1'b0;
    store_data = ch;
    emit       = 1'b0;
    emit_kind  = KIND_LINE;
    rem_d      = rem_e;
    acc_d      = acc_e;
    dend_d     = dend_e;
    if (rem_e != '0) begin
      store_en = 1'b1;
      rem_d    = rem_e - 1'b1;
      if (rem_d == '0) begin
        emit      = 1'b1;
        emit_kind = KIND_DATA;
      end
    end else if (ovf_e) begin
      store_en = 1'b0;
    end else if (ch == CH_LF) begin
      if (fill_e != '0) begin
        if ((fill_e > TAG_LEN) && tag_e) begin
          store_en   = 1'b1;
          store_data = CH_NUL;
          dend_d     = 1'b1;
          rem_d      = acc_e;
        end else begin
          emit = 1'b1;
        end
      end
    end else begin
      store_en = 1'b1;
      if (wr_room && (fill_e >= TAG_LEN) && !dend_e) begin
        if (is_digit) begin
          acc_d = (acc_sum > {{(SUM_W-LEN_W){1'b0}}, LEN_MAX}) ? LEN_MAX
                                                                : acc_sum[LEN_W-1:0];
        end else begin
          dend_d = 1'b1;
        end
      end
    end

    fill_s = (store_en && wr_room) ? fill_e + 1'b1 : fill_e;
    ovf_s  = ovf_e || (store_en && !wr_room);
    tag_d  = tag_e;
    if (store_en && wr_room && (fill_e < TAG_LEN)) begin
      tag_d = tag_e && (store_data == tag_char(fill_e[2:0]));
    end

    fill_d = fill_s;
    ovf_d  = ovf_s;
    bank_d = bank_q;
    last_d = rx_i.arrival_ms;
    if (emit) begin
      fill_d = '0;
      ovf_d  = 1'b0;
      rem_d  = '0;
      acc_d  = '0;
      dend_d = 1'b0;
      tag_d  = 1'b1;
      bank_d = !bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      rem_q  <= '0;
      acc_q  <= '0;
      dend_q <= 1'b0;
      tag_q  <= 1'b1;
      last_q <= '0;
      bank_q <= 1'b0;
    end else if (accept) begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      dend_q <= dend_d;
      tag_q  <= tag_d;
      last_q <= last_d;
      bank_q <= bank_d;
    end
  end

  assign we_o    = accept && store_en && wr_room;
  assign waddr_o = {bank_q, fill_e[AW-1:0]};
  assign wdata_o = store_data;

  assign push_o            = accept && emit;
  assign push_data_o.bank  = bank_q;
  assign push_data_o.len   = fill_s;
  assign push_data_o.kind  = emit_kind;
  assign push_data_o.trunc = ovf_s;

endmodule

@@ sv/alfr_back.sv @@
module alfr_back #(
  parameter int unsigned AW = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  alfr_pkg::alfr_frame_t       q_data_i,
  output logic                        q_pop_o,
  output logic                        busy_o,
  output logic                        re_o,
  output logic [AW:0]                 raddr_o,
  input  logic [alfr_pkg::BYTE_W-1:0] rdata_i,
  alfr_out_if.source                  frame_o
);
  import alfr_pkg::*;

  logic              act_q;
  logic              bank_q;
  logic [FILL_W-1:0] len_q;
  logic [FILL_W-1:0] idx_q;
  logic              kind_q, trunc_q;
  logic              rd_vld_q, rd_last_q, rd_kind_q, rd_trunc_q;
  logic              out_vld_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q, out_kind_q, out_trunc_q;

  logic              load_out;
  logic              issue;
  logic              issue_last;
  logic              pop;

  assign load_out   = rd_vld_q && (!out_vld_q || frame_o.ready);
  assign issue      = act_q && (!rd_vld_q || load_out);
  assign issue_last = ((idx_q + 1'b1) == len_q);
  assign pop        = !act_q && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        act_q <= 1'b1;
      end else if (issue && issue_last) begin
        act_q <= 1'b0;
      end
      if (issue) begin
        rd_vld_q <= 1'b1;
      end else if (load_out) begin
        rd_vld_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      bank_q  <= q_data_i.bank;
      len_q   <= q_data_i.len;
      kind_q  <= q_data_i.kind;
      trunc_q <= q_data_i.trunc;
      idx_q   <= '0;
    end else if (issue) begin
      idx_q <= idx_q + 1'b1;
    end
    if (issue) begin
      rd_last_q  <= issue_last;
      rd_kind_q  <= kind_q;
      rd_trunc_q <= trunc_q;
    end
    if (load_out) begin
      out_byte_q  <= rdata_i;
      out_last_q  <= rd_last_q;
      out_kind_q  <= rd_kind_q;
      out_trunc_q <= rd_trunc_q;
    end
  end

  assign q_pop_o = pop;
  assign busy_o  = act_q;
  assign re_o    = issue;
  assign raddr_o = {bank_q, idx_q[AW-1:0]};

  assign frame_o.valid      = out_vld_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.is_last    = out_last_q;
  assign frame_o.frame_kind = out_kind_q;
  assign frame_o.truncated  = out_trunc_q;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import alfr_pkg::*;

  localparam int unsigned STORE_BYTES = 64;
  localparam int unsigned STORE_AW = $clog2(STORE_BYTES);
  // cycles allowed after the last due frame byte before a register write or the verdict
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  // receiver back-pressure stretch, long enough for both frame banks to fill
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_BYTES = 50;
  localparam logic [47:0] RECV_TAG = "+recv=";

  // one frame byte as the block presents it
  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              is_last;
    logic              frame_kind;
    logic              truncated;
  } frame_out_t;

  // directed row: byte, ms since the previous byte, frame bytes due (-1: predictor only)
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic [TIME_W-1:0] step_ms;
    int                n_due;
  } dir_row_t;

  localparam int NDIR = 24;
  dir_row_t dir_tab [NDIR] = '{
    '{CH_LF,   32'd3,  0},   // empty line right after reset
    '{"O",     32'd1, -1},
    '{"K",     32'd10, -1},  // silence exactly equal to the timeout keeps the line
    '{CH_LF,   32'd0,  2},
    '{"+",     32'd1, -1},
    '{"r",     32'd1, -1},
    '{"e",     32'd1, -1},
    '{"c",     32'd1, -1},
    '{"v",     32'd1, -1},
    '{"=",     32'd1, -1},
    '{"2",     32'd1, -1},
    '{CH_LF,   32'd1,  0},   // header closed, two payload bytes follow
    '{8'h00,   32'd2, -1},
    '{8'hFF,   32'd1, 10},   // header, zero byte and payload
    '{"A",     32'd1, -1},
    '{"B",     32'd11, -1},  // one ms over the timeout drops the A
    '{CH_LF,   32'd1,  1},
    '{"X",     32'd0, -1},
    '{"Y",     32'hFFFF_FFF0, -1},  // clock runs backwards, no drop
    '{CH_LF,   32'd0,  2},
    '{CH_LF,   32'd1,  0},
    '{8'h80,   32'd1, -1},
    '{8'h7F,   32'd1, -1},
    '{CH_LF,   32'd1,  2}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [GAP_W-1:0]  cfg_wdata_i;

  alfr_in_if  rx_if ();
  alfr_out_if frame_if ();

  at_line_and_length_frame_receiver #(
    .STORE_BYTES(STORE_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_if),
    .frame_o    (frame_if)
  );

  // framer state as the predictor sees it
  logic [BYTE_W-1:0] fs_mem [STORE_BYTES];
  logic [FILL_W-1:0] fs_fill;
  logic              fs_ovf;
  logic [LEN_W-1:0]  fs_remain;
  logic [LEN_W-1:0]  fs_len;
  logic              fs_dig_end;
  logic [TIME_W-1:0] fs_last;
  logic [GAP_W-1:0]  gap_ms;

  frame_out_t        frame_bytes_due [$];
  logic [BYTE_W-1:0] burst [$];
  logic [TIME_W-1:0] cur_ms;

  int n_mismatch = 0;
  int bytes_in = 0;
  int n_results = 0;
  int n_line_frames = 0;
  int n_data_frames = 0;
  int n_trunc_frames = 0;
  bit quiet = 1'b0;
  bit rcv_holding = 1'b0;
  bit brk_next = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d frame bytes still due", frame_bytes_due.size());
    $display("simulation failed");
    $finish;
  end

  function automatic void flag_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic void fs_clear();
    fs_fill    = '0;
    fs_ovf     = 1'b0;
    fs_remain  = '0;
    fs_len     = '0;
    fs_dig_end = 1'b0;
  endfunction

  // append one byte, or mark overflow once the store is full
  function automatic void fs_put(input logic [BYTE_W-1:0] b);
    if (!fs_ovf && fs_fill < STORE_BYTES) begin
      fs_mem[fs_fill[STORE_AW-1:0]] = b;
      fs_fill++;
    end else begin
      fs_ovf = 1'b1;
    end
  endfunction

  // queue every stored byte as due, then start a fresh frame
  function automatic int fs_emit(input logic kind);
    int n;
    n = int'(fs_fill);
    for (int k = 0; k < n; k++)
      frame_bytes_due.push_back(frame_out_t'{fs_mem[k], k == n - 1, kind, fs_ovf});
    fs_clear();
    return n;
  endfunction

  function automatic logic fs_tagged();
    if (fs_fill <= TAG_LEN) return 1'b0;
    for (int i = 0; i < int'(TAG_LEN); i++)
      if (fs_mem[i] != RECV_TAG[47 - 8 * i -: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // advance the framer by one received byte, returns the number of frame bytes now due
  function automatic int framer_step(input logic [BYTE_W-1:0] c, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    logic [FILL_W-1:0] pos;
    logic [SUM_W-1:0]  v;
    int                n;
    n = 0;
    // silence beyond the timeout, judged as a signed 32-bit difference
    d = now - fs_last - {16'd0, gap_ms};
    if (d != '0 && !d[TIME_W-1]) fs_clear();
    fs_last = now;
    if (fs_remain != '0) begin
      fs_put(c);
      fs_remain--;
      if (fs_remain == '0) n = fs_emit(KIND_DATA);
    end else if (!fs_ovf) begin
      if (c == CH_LF) begin
        if (fs_fill != '0) begin
          if (fs_tagged()) begin
            fs_put(CH_NUL);
            fs_dig_end = 1'b1;
            fs_remain  = fs_len;
          end else begin
            n = fs_emit(KIND_LINE);
          end
        end
      end else begin
        pos = fs_fill;
        fs_put(c);
        if (!fs_ovf && pos >= TAG_LEN && !fs_dig_end) begin
          if (c >= CH_0 && c <= CH_9) begin
            v = {4'd0, fs_len} * 20'd10 + {12'd0, 8'(c - CH_0)};
            fs_len = (v > {4'd0, LEN_MAX}) ? LEN_MAX : v[LEN_W-1:0];
          end else begin
            fs_dig_end = 1'b1;
          end
        end
      end
    end
    return n;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom);
    if (b == CH_LF) b = 8'h0B;
    return b;
  endfunction

  function automatic void add_text_bytes(input int n);
    for (int i = 0; i < n; i++) burst.push_back(text_byte());
  endfunction

  function automatic void add_any_bytes(input int n);
    for (int i = 0; i < n; i++) burst.push_back(8'($urandom));
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endfunction

  // ms between two bytes of one frame; wild steps land anywhere
  function automatic logic [TIME_W-1:0] next_step(input logic wild);
    int r;
    if (wild) return $urandom();
    r = $urandom_range(0, 15);
    if (r == 0) return {16'd0, gap_ms};
    if (r == 1) return 32'h8000_0000 + 32'(gap_ms) + $urandom_range(0, 1 << 20);
    return $urandom_range(0, gap_ms);
  endfunction

  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t,
                            output int n);
    if (!quiet && !rcv_holding && $urandom_range(0, 4) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    rx_if.valid      <= 1'b1;
    rx_if.rx_byte    <= b;
    rx_if.arrival_ms <= t;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_in++;
    n = framer_step(b, t);
  endtask

  // one burst of traffic: mostly well-formed lines and counted frames, some noise
  task automatic play_burst();
    logic  brk;
    logic  wild;
    int    pick;
    int    num;
    int    pad;
    int    n;
    string hdr;
    burst.delete();
    brk      = brk_next || ($urandom_range(0, 3) == 0);
    brk_next = 1'b0;
    wild     = 1'b0;
    pick     = $urandom_range(0, 11);
    case (pick)
      0, 1, 2, 3: begin
        // command line, now and then past the store size
        num = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 12);
        add_text_bytes(num);
        burst.push_back(CH_LF);
        if (num > STORE_BYTES) brk_next = 1'b1;
      end
      4, 5, 6: begin
        // counted frame, sometimes long enough to truncate
        num = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 20);
        hdr = "+recv=";
        if ($urandom_range(0, 3) == 0) hdr = {hdr, "0"};
        hdr = {hdr, $sformatf("%0d", num)};
        add_str(hdr);
        if ($urandom_range(0, 3) == 0) begin
          // non-digit ends the length field
          case ($urandom_range(0, 3))
            0:       add_str(" ");
            1:       add_str("+");
            2:       add_str("-");
            default: add_str("x");
          endcase
          add_text_bytes($urandom_range(0, 3));
        end
        burst.push_back(CH_LF);
        if ($urandom_range(0, 5) == 0) begin
          // payload cut short by silence
          add_any_bytes($urandom_range(0, num - 1));
          brk_next = 1'b1;
        end else begin
          add_any_bytes(num);
        end
      end
      7: begin
        // zero or missing length keeps the header in line mode
        case ($urandom_range(0, 3))
          0:       add_str("+recv=0");
          1:       add_str("+recv=");
          2:       add_str("+recv=x5");
          default: add_str("+recv= 7");
        endcase
        burst.push_back(CH_LF);
        add_text_bytes($urandom_range(0, 4));
        burst.push_back(CH_LF);
        brk_next = 1'b1;
      end
      8: begin
        // length saturates, only a few payload bytes before silence
        case ($urandom_range(0, 3))
          0:       add_str("+recv=65535");
          1:       add_str("+recv=65536");
          2:       add_str("+recv=99999");
          default: add_str("+recv=4294967296");
        endcase
        burst.push_back(CH_LF);
        add_any_bytes($urandom_range(1, 4));
        brk_next = 1'b1;
      end
      9: begin
        // header padded up to the store size, zero byte may not fit
        num = $urandom_range(1, 5);
        hdr = $sformatf("+recv=%0dx", num);
        pad = $urandom_range(61, 66);
        add_str(hdr);
        add_text_bytes(pad - hdr.len());
        burst.push_back(CH_LF);
        add_any_bytes(num);
        brk_next = 1'b1;
      end
      10: begin
        add_any_bytes($urandom_range(1, 6));
        wild = 1'b1;
      end
      default: begin
        // unterminated line, dropped by the following silence
        add_text_bytes($urandom_range(1, 8));
        brk_next = 1'b1;
      end
    endcase
    foreach (burst[i]) begin
      if (i == 0 && brk) cur_ms += 32'(gap_ms) + 32'd1 + $urandom_range(0, 50);
      else cur_ms += next_step(wild);
      offer_byte(burst[i], cur_ms, n);
    end
  endtask

  task automatic random_phase(input int count);
    int start;
    start = bytes_in;
    while (bytes_in - start < count) play_burst();
  endtask

  // register write only once every due frame byte is out and the block has settled
  task automatic set_gap(input logic [GAP_W-1:0] v);
    rx_if.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gap_ms = v;
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    int n;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    rx_if.valid      <= 1'b0;
    rx_if.rx_byte    <= '0;
    rx_if.arrival_ms <= '0;
    gap_ms  = GAP_RESET;
    fs_last = '0;
    fs_clear();
    cur_ms = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows with the default timeout
    for (int i = 0; i < NDIR; i++) begin
      cur_ms += dir_tab[i].step_ms;
      offer_byte(dir_tab[i].rx_byte, cur_ms, n);
      if (dir_tab[i].n_due >= 0 && n != dir_tab[i].n_due)
        flag_mismatch($sformatf("row %0d: %0d frame bytes due, predictor gives %0d",
                                i, dir_tab[i].n_due, n));
    end

    // zero timeout: any advance of the clock drops the partial frame
    set_gap('0);
    random_phase(40);

    // widest timeout, starting from an arbitrary timestamp
    set_gap(16'hFFFF);
    cur_ms = $urandom();
    random_phase(50);

    set_gap(16'($urandom_range(1, 300)));
    random_phase(60);

    // back to the reset value, both sides at full rate
    set_gap(GAP_RESET);
    quiet = 1'b1;
    random_phase(50);
    rx_if.valid <= 1'b0;

    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display({"covered %0d input bytes and %0d frame bytes across timeouts ",
              "0, 10, 65535 and one random"}, bytes_in, n_results);
    $display("frames seen: %0d command lines, %0d counted data frames, %0d truncated",
             n_line_frames, n_data_frames, n_trunc_frames);
    if (n_mismatch == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- frame receiver and checker

  initial begin
    frame_out_t got;
    frame_out_t want;
    int         stall;
    int         hold;
    bit         held_once;
    stall = 0;
    hold = 0;
    held_once = 1'b0;
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
        got = '{frame_if.frame_byte, frame_if.is_last, frame_if.frame_kind, frame_if.truncated};
        n_results++;
        if (got.is_last === 1'b1) begin
          if (got.frame_kind === KIND_DATA) n_data_frames++;
          else n_line_frames++;
          if (got.truncated === 1'b1) n_trunc_frames++;
        end
        if (frame_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("frame byte %02h last %0b kind %0b trunc %0b with none due",
                                  got.frame_byte, got.is_last, got.frame_kind, got.truncated));
        end else begin
          want = frame_bytes_due.pop_front();
          if (got.frame_byte !== want.frame_byte || got.is_last !== want.is_last ||
              got.frame_kind !== want.frame_kind || got.truncated !== want.truncated)
            flag_mismatch($sformatf({"expected byte %02h last %0b kind %0b trunc %0b, ",
                                     "got byte %02h last %0b kind %0b trunc %0b"},
                                    want.frame_byte, want.is_last, want.frame_kind,
                                    want.truncated, got.frame_byte, got.is_last,
                                    got.frame_kind, got.truncated));
        end
      end

      // one long hold-off while the sender keeps offering, so both banks fill
      if (!held_once && bytes_in >= HOLD_AFTER_BYTES) begin
        held_once = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        rcv_holding = 1'b1;
        frame_if.ready <= 1'b0;
      end else begin
        rcv_holding = 1'b0;
        if (stall > 0) begin
          stall--;
          frame_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          stall = $urandom_range(1, 16) - 1;
          frame_if.ready <= 1'b0;
        end else begin
          frame_if.ready <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sim.f @@
sv/alfr_pkg.sv
sv/alfr_in_if.sv
sv/alfr_out_if.sv
sv/alfr_ram.sv
sv/alfr_queue.sv
sv/alfr_front.sv
sv/alfr_back.sv
sv/at_line_and_length_frame_receiver.sv
tb/sv/testbench.sv
